@@ design/pdh_pkg.sv @@
// package for the pair distance histogram: widths, codes, states
`timescale 1ns / 1ps
`default_nettype none
package pdh_pkg;
  localparam int unsigned NBINS_DEF   = 256;
  localparam int unsigned NPAIRS_DEF  = 4;
  localparam int unsigned COUNT_W_DEF = 32;

  localparam int unsigned CUT_W  = 50;
  localparam int unsigned BW_W   = 24;
  localparam int unsigned BIU_W  = 9;
  localparam int unsigned POS_W  = 24;
  localparam int unsigned RSQ_W  = 50;
  localparam int unsigned DIST_W = 25;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_TALLY = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_CUTOFF_SQ   = 2'd0,
    CFG_BIN_WIDTH   = 2'd1,
    CFG_BINS_IN_USE = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SQ,
    ST_SUM,
    ST_SQRT,
    ST_DIV,
    ST_BIN,
    ST_RD,
    ST_WR,
    ST_OUT
  } state_e;
endpackage
`default_nettype wire

@@ design/pdh_ram.sv @@
// generic single port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module pdh_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

@@ design/pair_distance_histogram_top.sv @@
// top level of the pair distance histogram
// channel  | direction | handshake          | payload
// s_axis   | in        | tvalid/tready      | tdata positions, read_bin; tuser op, class
// m_axis   | out       | tvalid/tready      | tdata counted, bin_index, bin_count, saturated
// cfg      | in        | cfg_valid/cfg_ready| register index, write data
// a tally runs 25 root steps and 25 divide steps between accept and result
// a read runs BIN, RD, WR, OUT; a clear sweeps NPAIRS*NBINS entries one per cycle
// after reset the store is cleared by the same sweep before items are taken
// one item at a time; a held result stalls the next item
`timescale 1ns / 1ps
`default_nettype none
module pair_distance_histogram_top #(
  parameter int unsigned NBINS   = pdh_pkg::NBINS_DEF,
  parameter int unsigned NPAIRS  = pdh_pkg::NPAIRS_DEF,
  parameter int unsigned COUNT_W = pdh_pkg::COUNT_W_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, read_bin
  input  wire logic [151:0] s_axis_tdata,
  // operation, pair_class
  input  wire logic [3:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // counted, bin_index, bin_count, saturated, zero fill
  output logic [47:0]       m_axis_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [63:0]  cfg_data
);
  localparam int unsigned DEPTH = NBINS * NPAIRS;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned BIW = $clog2(NBINS);
  localparam int unsigned CW = (NPAIRS > 1) ? $clog2(NPAIRS) : 1;
  localparam int unsigned SQ_W = 2 * (pdh_pkg::POS_W + 1);
  localparam logic [COUNT_W-1:0] CMAX = {COUNT_W{1'b1}};

  pdh_pkg::state_e state_q, state_d;

  logic [pdh_pkg::CUT_W-1:0] cutoff_q;
  logic [pdh_pkg::BW_W-1:0]  bw_q;
  logic [pdh_pkg::BIU_W-1:0] biu_q;

  logic [1:0]  op_q;
  logic [1:0]  cls_q;
  logic [7:0]  rb_q;
  logic signed [pdh_pkg::POS_W:0] dx_q, dy_q, dz_q;
  logic [SQ_W-1:0] sx_q, sy_q, sz_q;
  logic [pdh_pkg::RSQ_W+1:0] rsq_q;
  logic [5:0]  step_q;
  logic [pdh_pkg::RSQ_W+1:0] rem_q;
  logic [pdh_pkg::DIST_W-1:0] root_q;
  logic [pdh_pkg::DIST_W-1:0] quo_q;
  logic [pdh_pkg::BW_W:0]    drem_q;
  logic [AW:0]  clr_q;
  logic [AW-1:0] addr_q;
  logic [7:0]   idx_q;
  logic         valid_q;

  logic        o_cnt_q, o_sat_q;
  logic [7:0]  o_idx_q;
  logic [31:0] o_val_q;

  logic              we;
  logic [AW-1:0]     ram_addr;
  logic [COUNT_W-1:0] wdata, rdata;

  pdh_ram #(.Width(COUNT_W), .Depth(DEPTH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (ram_addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  assign cfg_ready = 1'b1;
  assign s_axis_tready = (state_q == pdh_pkg::ST_IDLE) && !m_axis_tvalid;
  assign m_axis_tdata = {6'd0, o_sat_q, o_val_q, o_idx_q, o_cnt_q};

  // root step: trial subtract of 4*root+1 shifted remainder
  logic [pdh_pkg::RSQ_W+1:0] rem_sh;
  logic [pdh_pkg::RSQ_W+1:0] trial;
  logic [1:0] pair_bits;
  always_comb begin
    pair_bits = rsq_q[2*pdh_pkg::DIST_W-1 - 2*(step_q[4:0]) -: 2];
    rem_sh = {rem_q[pdh_pkg::RSQ_W-1:0], pair_bits};
    trial = {{(pdh_pkg::RSQ_W-pdh_pkg::DIST_W){1'b0}}, root_q, 2'b01};
  end

  // divide step
  logic [pdh_pkg::BW_W+1:0] dsh;
  always_comb begin
    dsh = {drem_q, root_q[pdh_pkg::DIST_W-1 - step_q[4:0]]};
  end

  // limit and bin checks
  logic [pdh_pkg::BIU_W+BIW:0] limit;
  logic bin_ok;
  always_comb begin
    limit = (biu_q < (pdh_pkg::BIU_W+BIW+1)'(NBINS)) ? (pdh_pkg::BIU_W+BIW+1)'(biu_q)
                                                  : (pdh_pkg::BIU_W+BIW+1)'(NBINS);
    bin_ok = ((pdh_pkg::DIST_W+1)'(quo_q) < (pdh_pkg::DIST_W+1)'(limit));
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pdh_pkg::ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          unique case (s_axis_tuser[1:0])
            pdh_pkg::OP_CLEAR: state_d = pdh_pkg::ST_CLEAR;
            pdh_pkg::OP_TALLY: state_d = pdh_pkg::ST_SQ;
            pdh_pkg::OP_READ:  state_d = pdh_pkg::ST_BIN;
            default:           state_d = pdh_pkg::ST_OUT;
          endcase
        end
      end
      pdh_pkg::ST_CLEAR: if (clr_q == (AW+1)'(DEPTH - 1)) begin
        state_d = (op_q == pdh_pkg::OP_CLEAR) ? pdh_pkg::ST_OUT : pdh_pkg::ST_IDLE;
      end
      pdh_pkg::ST_SQ:   state_d = pdh_pkg::ST_SUM;
      pdh_pkg::ST_SUM:  state_d = pdh_pkg::ST_SQRT;
      pdh_pkg::ST_SQRT: if (step_q == 6'(pdh_pkg::DIST_W - 1)) state_d = pdh_pkg::ST_DIV;
      pdh_pkg::ST_DIV:  if (step_q == 6'(pdh_pkg::DIST_W - 1)) state_d = pdh_pkg::ST_BIN;
      pdh_pkg::ST_BIN:  state_d = pdh_pkg::ST_RD;
      pdh_pkg::ST_RD:   state_d = pdh_pkg::ST_WR;
      pdh_pkg::ST_WR:   state_d = pdh_pkg::ST_OUT;
      pdh_pkg::ST_OUT:  state_d = pdh_pkg::ST_IDLE;
      default:          state_d = pdh_pkg::ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    we = 1'b0;
    ram_addr = addr_q;
    wdata = '0;
    unique case (state_q)
      pdh_pkg::ST_CLEAR: begin
        we = 1'b1;
        ram_addr = clr_q[AW-1:0];
      end
      pdh_pkg::ST_WR: begin
        we = valid_q && (op_q == pdh_pkg::OP_TALLY) && (rdata != CMAX);
        wdata = rdata + COUNT_W'(1);
      end
      default: ;
    endcase
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= '0;
      bw_q <= pdh_pkg::BW_W'(4096);
      biu_q <= pdh_pkg::BIU_W'(256);
    end else if (cfg_valid) begin
      case (cfg_index)
        pdh_pkg::CFG_CUTOFF_SQ:   cutoff_q <= cfg_data[pdh_pkg::CUT_W-1:0];
        pdh_pkg::CFG_BIN_WIDTH:   bw_q <= cfg_data[pdh_pkg::BW_W-1:0];
        pdh_pkg::CFG_BINS_IN_USE: biu_q <= cfg_data[pdh_pkg::BIU_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pdh_pkg::ST_CLEAR;
      clr_q <= '0;
      op_q <= pdh_pkg::OP_NONE;
      m_axis_tvalid <= 1'b0;
      step_q <= '0;
    end else begin
      state_q <= state_d;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (state_q == pdh_pkg::ST_OUT) m_axis_tvalid <= 1'b1;
      if (state_q == pdh_pkg::ST_CLEAR) clr_q <= clr_q + (AW+1)'(1);
      else clr_q <= '0;
      if (state_q == pdh_pkg::ST_IDLE && s_axis_tvalid && s_axis_tready)
        op_q <= s_axis_tuser[1:0];
      if ((state_q == pdh_pkg::ST_SQRT || state_q == pdh_pkg::ST_DIV)
          && step_q != 6'(pdh_pkg::DIST_W - 1))
        step_q <= step_q + 6'd1;
      else
        step_q <= '0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      pdh_pkg::ST_IDLE: begin
        // capture only on accept so a held result stays intact
        if (s_axis_tvalid && s_axis_tready) begin
          cls_q <= s_axis_tuser[3:2];
          rb_q <= s_axis_tdata[151:144];
          dx_q <= $signed({s_axis_tdata[23], s_axis_tdata[23:0]})
                - $signed({s_axis_tdata[95], s_axis_tdata[95:72]});
          dy_q <= $signed({s_axis_tdata[47], s_axis_tdata[47:24]})
                - $signed({s_axis_tdata[119], s_axis_tdata[119:96]});
          dz_q <= $signed({s_axis_tdata[71], s_axis_tdata[71:48]})
                - $signed({s_axis_tdata[143], s_axis_tdata[143:120]});
          o_cnt_q <= 1'b0;
          o_sat_q <= 1'b0;
          o_idx_q <= '0;
          o_val_q <= '0;
          valid_q <= 1'b0;
        end
      end
      pdh_pkg::ST_SQ: begin
        sx_q <= SQ_W'(dx_q * dx_q);
        sy_q <= SQ_W'(dy_q * dy_q);
        sz_q <= SQ_W'(dz_q * dz_q);
      end
      pdh_pkg::ST_SUM: begin
        rsq_q <= (pdh_pkg::RSQ_W+2)'(sx_q) + (pdh_pkg::RSQ_W+2)'(sy_q)
               + (pdh_pkg::RSQ_W+2)'(sz_q);
        rem_q <= '0;
        root_q <= '0;
      end
      pdh_pkg::ST_SQRT: begin
        if (rem_sh >= trial) begin
          rem_q <= rem_sh - trial;
          root_q <= {root_q[pdh_pkg::DIST_W-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          root_q <= {root_q[pdh_pkg::DIST_W-2:0], 1'b0};
        end
        drem_q <= '0;
      end
      pdh_pkg::ST_DIV: begin
        if (dsh >= (pdh_pkg::BW_W+2)'(bw_q)) begin
          drem_q <= (pdh_pkg::BW_W+1)'(dsh - (pdh_pkg::BW_W+2)'(bw_q));
          quo_q <= {quo_q[pdh_pkg::DIST_W-2:0], 1'b1};
        end else begin
          drem_q <= dsh[pdh_pkg::BW_W:0];
          quo_q <= {quo_q[pdh_pkg::DIST_W-2:0], 1'b0};
        end
      end
      pdh_pkg::ST_BIN: begin
        if (op_q == pdh_pkg::OP_TALLY) begin
          valid_q <= (rsq_q < (pdh_pkg::RSQ_W+2)'(cutoff_q)) && (bw_q != '0)
                     && ((CW+1)'(cls_q) < (CW+1)'(NPAIRS)) && bin_ok;
          addr_q <= AW'(cls_q) * AW'(NBINS) + AW'(quo_q[BIW-1:0]);
          idx_q <= quo_q[7:0];
        end else begin
          valid_q <= ((CW+1)'(cls_q) < (CW+1)'(NPAIRS)) && ((BIW+9)'(rb_q) < (BIW+9)'(NBINS));
          addr_q <= AW'(cls_q) * AW'(NBINS) + AW'(rb_q);
          idx_q <= rb_q;
        end
      end
      pdh_pkg::ST_WR: begin
        if (op_q == pdh_pkg::OP_TALLY) begin
          if (valid_q) begin
            o_idx_q <= idx_q;
            o_cnt_q <= (rdata != CMAX);
            o_sat_q <= (rdata >= CMAX - COUNT_W'(1));
            o_val_q <= 32'((rdata == CMAX) ? rdata : rdata + COUNT_W'(1));
          end
        end else begin
          o_idx_q <= idx_q;
          if (valid_q) begin
            o_sat_q <= (rdata == CMAX);
            o_val_q <= 32'(rdata);
          end
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire
